// ===== hdl/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Types, constants and helper functions shared by the integer-to-ASCII
// formatter: microcode word layout, step addresses and character codes.
// ----------------------------------------------------------------------------
package ita_pkg;

    localparam int MAX_DIGITS = 16;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);
    localparam int UPC_W      = 4;

    // Conversion codes
    localparam logic [2:0] CMD_CHAR = 3'd0;
    localparam logic [2:0] CMD_SDEC = 3'd1;
    localparam logic [2:0] CMD_UDEC = 3'd2;
    localparam logic [2:0] CMD_HEXL = 3'd3;
    localparam logic [2:0] CMD_HEXU = 3'd4;
    localparam logic [2:0] CMD_PTR  = 3'd5;
    localparam logic [2:0] CMD_PCT  = 3'd6;

    // Character codes
    localparam logic [7:0] ASC_ZERO    = 8'h30;
    localparam logic [7:0] ASC_X       = 8'h78;
    localparam logic [7:0] ASC_MINUS   = 8'h2D;
    localparam logic [7:0] ASC_PERCENT = 8'h25;
    localparam logic [7:0] ASC_UPPER_A = 8'h37;   // 'A' - 10
    localparam logic [7:0] ASC_LOWER_A = 8'h57;   // 'a' - 10

    // ceil(2^35 / 10): floor(v * RECIP10 / 2^35) == v / 10 for any 32-bit v
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

    typedef logic [UPC_W-1:0] upc_t;

    // Microprogram addresses
    localparam upc_t UA_WAIT   = 4'd0;
    localparam upc_t UA_CHAR   = 4'd1;
    localparam upc_t UA_PCT    = 4'd2;
    localparam upc_t UA_SIGN   = 4'd3;
    localparam upc_t UA_MINUS  = 4'd4;
    localparam upc_t UA_DECMUL = 4'd5;
    localparam upc_t UA_DECDIV = 4'd6;
    localparam upc_t UA_PTR0   = 4'd7;
    localparam upc_t UA_PTRX   = 4'd8;
    localparam upc_t UA_OUTD   = 4'd9;
    localparam upc_t UA_HEXD   = 4'd10;

    typedef enum logic [2:0] {
        UOP_NONE,
        UOP_WAIT,
        UOP_EMIT,
        UOP_MUL,
        UOP_DIVSTORE,
        UOP_HEXSTORE,
        UOP_OUTDIGIT
    } uop_t;

    typedef enum logic [2:0] {
        SRC_ARG,
        SRC_PERCENT,
        SRC_MINUS,
        SRC_ZERO,
        SRC_X
    } src_t;

    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_DISPATCH,
        JC_NEG,
        JC_MORE,
        JC_LAST
    } jcond_t;

    typedef struct packed {
        uop_t   op;
        src_t   src;
        logic   last;
        jcond_t jc;
        upc_t   jump_true;
        upc_t   jump_false;
    } uword_t;

    typedef struct packed {
        uop_t op;
        src_t src;
        logic last;
        logic fire;
    } ctrl_t;

    typedef struct packed {
        logic neg;
        logic more;
        logic last_digit;
        logic out_free;
    } status_t;

    function automatic upc_t dispatch(input logic [2:0] c);
        upc_t a;
        case (c)
            CMD_CHAR: a = UA_CHAR;
            CMD_SDEC: a = UA_SIGN;
            CMD_UDEC: a = UA_DECMUL;
            CMD_HEXL: a = UA_HEXD;
            CMD_HEXU: a = UA_HEXD;
            CMD_PTR:  a = UA_PTR0;
            CMD_PCT:  a = UA_PCT;
            default:  a = UA_WAIT;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] digit_ascii(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10)
        begin
            c = {4'h0, d} + ASC_ZERO;
        end
        else
        begin
            c = {4'h0, d} + (upper ? ASC_UPPER_A : ASC_LOWER_A);
        end
        return c;
    endfunction

endpackage

// ===== hdl/integer_to_ascii_formatter.sv =====
// Flow: a number is first split into digits (a multiply step and a divide step per decimal
// digit through the reciprocal multiplier, a single store step per hex digit), then one
// character leaves per cycle unless the output stalls.
// Requests: one at a time; a new request is taken only once the last one is done.
// Reset: asynchronous active low; sequencer returns to waiting, output empty, count zero.
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Microcoded printf-style integer conversion: char, signed/unsigned decimal,
// lower/upper hex, pointer and percent, one ASCII character per result.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [63:0] arg_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_char,
    output logic        last_char,
    output logic [31:0] total_written
);

    ita_pkg::ctrl_t   ctrl;
    ita_pkg::status_t status;

    ita_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cmd      (cmd),
        .status   (status),
        .ctrl     (ctrl),
        .in_stall (in_stall)
    );

    ita_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .cmd           (cmd),
        .arg_value     (arg_value),
        .status        (status),
        .out_char      (out_char),
        .last_char     (last_char),
        .total_written (total_written),
        .out_valid     (out_valid),
        .out_stall     (out_stall)
    );

endmodule

// ===== hdl/ita_ucode_rom.sv =====
// ----------------------------------------------------------------------------
// ita_ucode_rom
// Read-only control store: one control word per microprogram step.
// ----------------------------------------------------------------------------
module ita_ucode_rom (
    input  ita_pkg::upc_t   addr,
    output ita_pkg::uword_t word
);

    always_comb
    begin
        case (addr)
            ita_pkg::UA_WAIT:
                word = '{op: ita_pkg::UOP_WAIT, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_DISPATCH,
                         jump_true: ita_pkg::UA_WAIT, jump_false: ita_pkg::UA_WAIT};
            ita_pkg::UA_CHAR:
                word = '{op: ita_pkg::UOP_EMIT, src: ita_pkg::SRC_ARG, last: 1'b1,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_WAIT, jump_false: ita_pkg::UA_WAIT};
            ita_pkg::UA_PCT:
                word = '{op: ita_pkg::UOP_EMIT, src: ita_pkg::SRC_PERCENT, last: 1'b1,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_WAIT, jump_false: ita_pkg::UA_WAIT};
            ita_pkg::UA_SIGN:
                word = '{op: ita_pkg::UOP_NONE, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_NEG,
                         jump_true: ita_pkg::UA_MINUS, jump_false: ita_pkg::UA_DECMUL};
            ita_pkg::UA_MINUS:
                word = '{op: ita_pkg::UOP_EMIT, src: ita_pkg::SRC_MINUS, last: 1'b0,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_DECMUL, jump_false: ita_pkg::UA_DECMUL};
            ita_pkg::UA_DECMUL:
                word = '{op: ita_pkg::UOP_MUL, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_DECDIV, jump_false: ita_pkg::UA_DECDIV};
            ita_pkg::UA_DECDIV:
                word = '{op: ita_pkg::UOP_DIVSTORE, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_MORE,
                         jump_true: ita_pkg::UA_DECMUL, jump_false: ita_pkg::UA_OUTD};
            ita_pkg::UA_PTR0:
                word = '{op: ita_pkg::UOP_EMIT, src: ita_pkg::SRC_ZERO, last: 1'b0,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_PTRX, jump_false: ita_pkg::UA_PTRX};
            ita_pkg::UA_PTRX:
                word = '{op: ita_pkg::UOP_EMIT, src: ita_pkg::SRC_X, last: 1'b0,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_HEXD, jump_false: ita_pkg::UA_HEXD};
            ita_pkg::UA_OUTD:
                word = '{op: ita_pkg::UOP_OUTDIGIT, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_LAST,
                         jump_true: ita_pkg::UA_WAIT, jump_false: ita_pkg::UA_OUTD};
            ita_pkg::UA_HEXD:
                word = '{op: ita_pkg::UOP_HEXSTORE, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_MORE,
                         jump_true: ita_pkg::UA_HEXD, jump_false: ita_pkg::UA_OUTD};
            default:
                word = '{op: ita_pkg::UOP_NONE, src: ita_pkg::SRC_ARG, last: 1'b0,
                         jc: ita_pkg::JC_ALWAYS,
                         jump_true: ita_pkg::UA_WAIT, jump_false: ita_pkg::UA_WAIT};
        endcase
    end

endmodule

// ===== hdl/ita_sequencer.sv =====
// ----------------------------------------------------------------------------
// ita_sequencer
// Step counter with conditional and dispatch jumps over the control store.
// A step only advances once its handshake condition is met.
// ----------------------------------------------------------------------------
module ita_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [2:0]        cmd,
    input  ita_pkg::status_t  status,
    output ita_pkg::ctrl_t    ctrl,
    output logic              in_stall
);

    ita_pkg::upc_t   upc_reg;
    ita_pkg::upc_t   upc_next;
    ita_pkg::upc_t   target;
    ita_pkg::uword_t word;
    logic            fire;

    ita_ucode_rom u_rom (
        .addr (upc_reg),
        .word (word)
    );

    always_comb
    begin
        case (word.jc)
            ita_pkg::JC_ALWAYS:   target = word.jump_true;
            ita_pkg::JC_DISPATCH: target = ita_pkg::dispatch(cmd);
            ita_pkg::JC_NEG:      target = status.neg ? word.jump_true : word.jump_false;
            ita_pkg::JC_MORE:     target = status.more ? word.jump_true : word.jump_false;
            ita_pkg::JC_LAST:     target = status.last_digit ? word.jump_true : word.jump_false;
            default:              target = word.jump_true;
        endcase

        case (word.op)
            ita_pkg::UOP_WAIT:     fire = in_valid;
            ita_pkg::UOP_EMIT:     fire = status.out_free;
            ita_pkg::UOP_OUTDIGIT: fire = status.out_free;
            default:               fire = 1'b1;
        endcase

        upc_next  = fire ? target : upc_reg;
        in_stall  = (word.op != ita_pkg::UOP_WAIT);
        ctrl.op   = word.op;
        ctrl.src  = word.src;
        ctrl.last = word.last;
        ctrl.fire = fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= ita_pkg::UA_WAIT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== hdl/ita_datapath.sv =====
// ----------------------------------------------------------------------------
// ita_datapath
// Operand register, divide-by-ten via reciprocal multiply, digit store,
// character counter and the output register.
// ----------------------------------------------------------------------------
module ita_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  ita_pkg::ctrl_t    ctrl,
    input  logic [2:0]        cmd,
    input  logic [63:0]       arg_value,
    output ita_pkg::status_t  status,
    output logic [7:0]        out_char,
    output logic              last_char,
    output logic [31:0]       total_written,
    output logic              out_valid,
    input  logic              out_stall
);

    logic [63:0]                value_reg;
    logic [63:0]                value_next;
    logic [63:0]                prod_reg;
    logic [63:0]                prod_next;
    logic                       neg_reg;
    logic                       neg_next;
    logic                       upper_reg;
    logic                       upper_next;
    logic [ita_pkg::CNT_W-1:0]  count_reg;
    logic [ita_pkg::CNT_W-1:0]  count_next;
    logic [ita_pkg::CNT_W-1:0]  count_dec;
    logic [3:0]                 digit_store [ita_pkg::MAX_DIGITS];
    logic [3:0]                 rd_digit_reg;
    logic [ita_pkg::CNT_W-1:0]  rd_pos;
    logic                       store_en;
    logic [3:0]                 store_digit;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [7:0]                 out_char_reg;
    logic [7:0]                 out_char_next;
    logic                       out_last_reg;
    logic                       out_last_next;
    logic [31:0]                total_reg;
    logic [31:0]                total_next;

    logic [31:0]                low;
    logic                       neg_load;
    logic [31:0]                mag;
    logic [28:0]                quot;
    logic [31:0]                quot10;
    logic [31:0]                rem;
    logic                       room;
    logic                       emit_fire;
    logic [7:0]                 emit_char;
    logic                       emit_last;

    always_comb
    begin
        low      = arg_value[31:0];
        neg_load = (cmd == ita_pkg::CMD_SDEC) && low[31];
        mag      = neg_load ? (~low + 32'd1) : low;

        prod_next = value_reg[31:0] * ita_pkg::RECIP10;
        quot      = prod_reg[63:35];
        quot10    = {quot, 3'b000} + {2'b00, quot, 1'b0};
        rem       = value_reg[31:0] - quot10;

        count_dec = count_reg - 1'b1;
        room      = (count_reg < ita_pkg::CNT_W'(ita_pkg::MAX_DIGITS - 1));

        value_next  = value_reg;
        neg_next    = neg_reg;
        upper_next  = upper_reg;
        count_next  = count_reg;
        store_en    = 1'b0;
        store_digit = rem[3:0];
        status.more = 1'b0;

        case (ctrl.op)
            ita_pkg::UOP_WAIT:
            begin
                if (ctrl.fire)
                begin
                    value_next = (cmd == ita_pkg::CMD_PTR) ? arg_value : {32'b0, mag};
                    neg_next   = neg_load;
                    upper_next = (cmd == ita_pkg::CMD_HEXU);
                    count_next = '0;
                end
            end
            ita_pkg::UOP_DIVSTORE:
            begin
                store_en    = 1'b1;
                store_digit = rem[3:0];
                value_next  = {35'b0, quot};
                count_next  = count_reg + 1'b1;
                status.more = (quot != 29'd0) && room;
            end
            ita_pkg::UOP_HEXSTORE:
            begin
                store_en    = 1'b1;
                store_digit = value_reg[3:0];
                value_next  = {4'h0, value_reg[63:4]};
                count_next  = count_reg + 1'b1;
                status.more = (value_reg[63:4] != 60'd0) && room;
            end
            ita_pkg::UOP_OUTDIGIT:
            begin
                if (ctrl.fire)
                begin
                    count_next = count_dec;
                end
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase

        // digit wanted by the next step sits just below the next count
        rd_pos = count_next - 1'b1;

        case (ctrl.src)
            ita_pkg::SRC_ARG:     emit_char = value_reg[7:0];
            ita_pkg::SRC_PERCENT: emit_char = ita_pkg::ASC_PERCENT;
            ita_pkg::SRC_MINUS:   emit_char = ita_pkg::ASC_MINUS;
            ita_pkg::SRC_ZERO:    emit_char = ita_pkg::ASC_ZERO;
            ita_pkg::SRC_X:       emit_char = ita_pkg::ASC_X;
            default:              emit_char = value_reg[7:0];
        endcase
        emit_last = ctrl.last;
        if (ctrl.op == ita_pkg::UOP_OUTDIGIT)
        begin
            emit_char = ita_pkg::digit_ascii(rd_digit_reg, upper_reg);
            emit_last = (count_reg == ita_pkg::CNT_W'(1));
        end

        status.neg        = neg_reg;
        status.last_digit = (count_reg == ita_pkg::CNT_W'(1));
        status.out_free   = !out_valid_reg || !out_stall;

        emit_fire = ctrl.fire &&
                    ((ctrl.op == ita_pkg::UOP_EMIT) || (ctrl.op == ita_pkg::UOP_OUTDIGIT));

        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (emit_fire)
        begin
            out_char_next  = emit_char;
            out_last_next  = emit_last;
            total_next     = total_reg + 32'd1;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= 32'd0;
            neg_reg       <= 1'b0;
            upper_reg     <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            total_reg     <= total_next;
            neg_reg       <= neg_next;
            upper_reg     <= upper_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (ctrl.op == ita_pkg::UOP_MUL)
        begin
            prod_reg <= prod_next;
        end
        if (store_en)
        begin
            digit_store[count_reg[ita_pkg::IDX_W-1:0]] <= store_digit;
        end
        // last stored digit is the first one read back, so forward it
        if (store_en && (rd_pos[ita_pkg::IDX_W-1:0] == count_reg[ita_pkg::IDX_W-1:0]))
        begin
            rd_digit_reg <= store_digit;
        end
        else
        begin
            rd_digit_reg <= digit_store[rd_pos[ita_pkg::IDX_W-1:0]];
        end
    end

    assign out_char      = out_char_reg;
    assign last_char     = out_last_reg;
    assign total_written = total_reg;
    assign out_valid     = out_valid_reg;

endmodule
